// ----- sv/bitmap_line_rasterizer_top_macros.svh -----
// Assertion helpers for the checker module.
`ifndef BITMAP_LINE_RASTERIZER_TOP_MACROS_SVH
`define BITMAP_LINE_RASTERIZER_TOP_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define BLR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds while its word is stalled.
`define BLR_ASSERT_STABLE(label, clk, rst_n, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/blr_pkg.sv -----
package blr_pkg;

  localparam int MAX_DIM    = 64;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int IN_W       = 8;
  localparam int COORD_W    = 6;
  localparam int ADDR_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BITMAP_WIDTH  = 2'd0,
    REG_BITMAP_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_REJECT
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } walk_cmd_t;

  typedef struct packed {
    logic reject;
    logic at_end;
  } walk_sts_t;

  typedef struct packed {
    logic valid;
    logic rejected;
    logic last;
  } emit_t;

  // Saturate a size register to the largest bitmap dimension.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] r);
    logic [DIM_W-1:0] res;
    if (r > CFG_DATA_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(r);
    end
    return res;
  endfunction

endpackage

// ----- sv/blr_if.sv -----
interface blr_cfg_if import blr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface blr_line_if import blr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] start_x;
  logic signed [IN_W-1:0] start_y;
  logic signed [IN_W-1:0] delta_x;
  logic signed [IN_W-1:0] delta_y;

  modport source (output valid, start_x, start_y, delta_x, delta_y, input ready);
  modport sink (input valid, start_x, start_y, delta_x, delta_y, output ready);
endinterface

interface blr_pixel_if import blr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic               rejected;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, pixel_address, rejected, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_address, rejected, last,
                output ready);
endinterface

// ----- sv/blr_walk.sv -----
module blr_walk import blr_pkg::*; (
  input  logic                   clk_i,
  input  walk_cmd_t              cmd_i,
  input  logic signed [IN_W-1:0] start_x_i,
  input  logic signed [IN_W-1:0] start_y_i,
  input  logic signed [IN_W-1:0] delta_x_i,
  input  logic signed [IN_W-1:0] delta_y_i,
  input  logic [DIM_W-1:0]       width_i,
  input  logic [DIM_W-1:0]       height_i,
  output logic [COORD_W-1:0]     pix_x_o,
  output logic [COORD_W-1:0]     pix_y_o,
  output walk_sts_t              sts_o
);

  logic signed [IN_W-1:0] x0_q, y0_q, dx_q, dy_q;
  logic [COORD_W-1:0]     cx_q, cx_d, cy_q, cy_d;
  logic [COORD_W-1:0]     accu_q, accu_d, major_q, minor_q, k_q;
  logic                   xmajor_q, xneg_q, yneg_q;

  logic signed [IN_W+1:0] xs, ys, xe, ye, wl, hl;
  logic [IN_W-1:0]        adx, ady, major, minor;
  logic                   xmaj;
  logic [COORD_W:0]       sum;
  logic                   wrap;
  logic [COORD_W-1:0]     cx_nx, cy_nx;

  // Endpoint range check against the live bitmap size.
  always_comb begin
    xs = {{2{x0_q[IN_W-1]}}, x0_q};
    ys = {{2{y0_q[IN_W-1]}}, y0_q};
    xe = xs + {{2{dx_q[IN_W-1]}}, dx_q};
    ye = ys + {{2{dy_q[IN_W-1]}}, dy_q};
    wl = (IN_W+2)'(width_i);
    hl = (IN_W+2)'(height_i);
    sts_o.reject = (xs < 0) || (ys < 0) || (xe < 0) || (ye < 0) ||
                   (xs >= wl) || (ys >= hl) || (xe >= wl) || (ye >= hl);
    sts_o.at_end = (k_q == major_q);
  end

  // Major and minor lengths.
  always_comb begin
    adx   = dx_q[IN_W-1] ? IN_W'(-dx_q) : IN_W'(dx_q);
    ady   = dy_q[IN_W-1] ? IN_W'(-dy_q) : IN_W'(dy_q);
    xmaj  = !(adx < ady);
    major = xmaj ? adx : ady;
    minor = xmaj ? ady : adx;
  end

  // Shared error-term adder and compare.
  always_comb begin
    sum    = {1'b0, accu_q} + {1'b0, minor_q};
    wrap   = (sum >= {1'b0, major_q});
    accu_d = wrap ? COORD_W'(sum - {1'b0, major_q}) : sum[COORD_W-1:0];
    cx_nx  = xneg_q ? cx_q - COORD_W'(1) : cx_q + COORD_W'(1);
    cy_nx  = yneg_q ? cy_q - COORD_W'(1) : cy_q + COORD_W'(1);
    cx_d   = (xmajor_q || wrap) ? cx_nx : cx_q;
    cy_d   = (!xmajor_q || wrap) ? cy_nx : cy_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= start_x_i;
      y0_q <= start_y_i;
      dx_q <= delta_x_i;
      dy_q <= delta_y_i;
    end
    if (cmd_i.setup) begin
      cx_q     <= x0_q[COORD_W-1:0];
      cy_q     <= y0_q[COORD_W-1:0];
      major_q  <= major[COORD_W-1:0];
      minor_q  <= minor[COORD_W-1:0];
      accu_q   <= major[COORD_W:1];
      k_q      <= '0;
      xmajor_q <= xmaj;
      xneg_q   <= dx_q[IN_W-1] || (dx_q == 0);
      yneg_q   <= dy_q[IN_W-1] || (dy_q == 0);
    end else if (cmd_i.step) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      accu_q <= accu_d;
      k_q    <= k_q + COORD_W'(1);
    end
  end

  assign pix_x_o = cx_q;
  assign pix_y_o = cy_q;

endmodule

// ----- sv/blr_ctrl.sv -----
module blr_ctrl import blr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  walk_sts_t sts_i,
  output logic      in_ready_o,
  output walk_cmd_t cmd_o,
  output emit_t     emit_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SETUP;
      ST_SETUP:  state_d = sts_i.reject ? ST_REJECT : ST_RUN;
      ST_RUN:    if (out_free_i && sts_i.at_end) state_d = ST_IDLE;
      ST_REJECT: if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.setup     = (state_q == ST_SETUP);
    cmd_o.step      = (state_q == ST_RUN) && out_free_i && !sts_i.at_end;
    emit_o.valid    = ((state_q == ST_RUN) || (state_q == ST_REJECT)) && out_free_i;
    emit_o.rejected = (state_q == ST_REJECT);
    emit_o.last     = (state_q == ST_REJECT) || sts_i.at_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/blr_out.sv -----
module blr_out import blr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  emit_t              emit_i,
  input  logic [COORD_W-1:0] pix_x_i,
  input  logic [COORD_W-1:0] pix_y_i,
  input  logic [DIM_W-1:0]   width_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               free_o,
  output logic [COORD_W-1:0] pixel_x_o,
  output logic [COORD_W-1:0] pixel_y_o,
  output logic [ADDR_W-1:0]  pixel_address_o,
  output logic               rejected_o,
  output logic               last_o
);

  logic                       valid_q;
  logic [COORD_W-1:0]         x_q, y_q;
  logic [ADDR_W-1:0]          addr_q;
  logic                       rej_q, last_q;
  logic [COORD_W+DIM_W-1:0]   prod, lin;

  // Row offset times width plus column.
  always_comb begin
    prod = (COORD_W+DIM_W)'(pix_y_i) * (COORD_W+DIM_W)'(width_i);
    lin  = prod + (COORD_W+DIM_W)'(pix_x_i);
  end

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_i.valid) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      x_q    <= emit_i.rejected ? '0 : pix_x_i;
      y_q    <= emit_i.rejected ? '0 : pix_y_i;
      addr_q <= emit_i.rejected ? '0 : lin[ADDR_W-1:0];
      rej_q  <= emit_i.rejected;
      last_q <= emit_i.last;
    end
  end

  assign valid_o         = valid_q;
  assign pixel_x_o       = x_q;
  assign pixel_y_o       = y_q;
  assign pixel_address_o = addr_q;
  assign rejected_o      = rej_q;
  assign last_o          = last_q;

endmodule

// ----- sv/bitmap_line_rasterizer_top.sv -----
// After a line word is taken, the sequencer sets up the walk, and the first
//   pixel word is then registered in the output register.
// Throughput: one pixel word per cycle while the sink keeps ready high; sink
//   stalls hold the walk; the next line is taken after the last word is out.
// A rejected line yields a single word.
// Reset: width and height return to 64, the output register empties, the
//   sequencer goes idle.
module bitmap_line_rasterizer_top import blr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  blr_cfg_if.sink     cfg_i,
  blr_line_if.sink    line_i,
  blr_pixel_if.source pixel_o
);

  // Size registers; write them only while no line is in flight.
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [DIM_W-1:0]      width_eff, height_eff;

  walk_cmd_t          cmd;
  walk_sts_t          sts;
  emit_t              emit;
  logic               out_free;
  logic [COORD_W-1:0] pix_x, pix_y;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(MAX_DIM);
      height_q <= CFG_DATA_W'(MAX_DIM);
    end else if (cfg_i.valid) begin
      // Drop writes to indexes beyond the register list.
      unique case (cfg_i.index)
        REG_BITMAP_WIDTH:  width_q  <= cfg_i.data;
        REG_BITMAP_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp oversized settings; a zero size rejects every line.
  assign width_eff  = eff_dim(width_q);
  assign height_eff = eff_dim(height_q);

  // Sequencer: take a line, set up the walk, then emit one pixel per free slot, or a single reject word.
  blr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (line_i.ready),
    .cmd_o      (cmd),
    .emit_o     (emit)
  );

  // Walk unit: one adder and compare on the error term advance the major coordinate
  // every step and the minor coordinate when the term wraps.
  blr_walk u_walk (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .start_x_i (line_i.start_x),
    .start_y_i (line_i.start_y),
    .delta_x_i (line_i.delta_x),
    .delta_y_i (line_i.delta_y),
    .width_i   (width_eff),
    .height_i  (height_eff),
    .pix_x_o   (pix_x),
    .pix_y_o   (pix_y),
    .sts_o     (sts)
  );

  // Output register: forms the linear address and holds the word for the sink.
  blr_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .emit_i          (emit),
    .pix_x_i         (pix_x),
    .pix_y_i         (pix_y),
    .width_i         (width_eff),
    .ready_i         (pixel_o.ready),
    .valid_o         (pixel_o.valid),
    .free_o          (out_free),
    .pixel_x_o       (pixel_o.pixel_x),
    .pixel_y_o       (pixel_o.pixel_y),
    .pixel_address_o (pixel_o.pixel_address),
    .rejected_o      (pixel_o.rejected),
    .last_o          (pixel_o.last)
  );

endmodule

// ----- sv/blr_checker.sv -----
`include "bitmap_line_rasterizer_top_macros.svh"

module blr_checker import blr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COORD_W-1:0] pixel_x_i,
  input logic [COORD_W-1:0] pixel_y_i,
  input logic [ADDR_W-1:0]  pixel_address_i,
  input logic               rejected_i,
  input logic               last_i
);

  `BLR_ASSERT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "pixel word dropped while stalled")
  `BLR_ASSERT_STABLE(a_out_addr_hold, clk_i, rst_ni, out_valid_i, out_ready_i, pixel_address_i, "address changed while stalled")
  `BLR_ASSERT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "line taken while busy")
  `BLR_ASSERT(a_reject_word, clk_i, rst_ni, out_valid_i && rejected_i |-> last_i && pixel_x_i == 0 && pixel_y_i == 0 && pixel_address_i == 0, "malformed reject word")

endmodule

bind bitmap_line_rasterizer_top blr_checker u_blr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (line_i.valid),
  .in_ready_i      (line_i.ready),
  .out_valid_i     (pixel_o.valid),
  .out_ready_i     (pixel_o.ready),
  .pixel_x_i       (pixel_o.pixel_x),
  .pixel_y_i       (pixel_o.pixel_y),
  .pixel_address_i (pixel_o.pixel_address),
  .rejected_i      (pixel_o.rejected),
  .last_i          (pixel_o.last)
);
